FILE: rtl/mel_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the metric edge length core.
// No dependencies; every other file refers to this package by scoped names.
package mel_pkg;

  typedef logic [31:0] word_t;
  typedef logic [63:0] dword_t;

  // Configuration register indexes
  localparam logic CFG_DIM = 1'b0;
  localparam logic CFG_THR = 1'b1;

  localparam logic [1:0] DIM_2D = 2'd2;

  // Fractional bits of the log2 result and length of the division
  localparam int LOG_FRAC_BITS = 58;
  localparam int DIV_BITS      = 32 + LOG_FRAC_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_BITS);

  // ln 2 in Q0.64
  localparam dword_t LN2_Q64 = 64'hB17217F7D1CF79AB;

  // Magnitude of a signed 32-bit value as unsigned
  function automatic word_t mag32(input word_t v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: rtl/mel_mul.sv
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with registered product.
// Depends on mel_pkg.
module mel_mul (
  input  logic           clk_i,
  input  mel_pkg::word_t a_i,
  input  mel_pkg::word_t b_i,
  output mel_pkg::dword_t p_o
);

  mel_pkg::dword_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;

endmodule

FILE: rtl/mel_sqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on mel_pkg.
module mel_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mel_pkg::dword_t radicand_i,
  output logic            done_o,
  output mel_pkg::word_t  root_o
);

  mel_pkg::dword_t rem_q, rem_d, res_q, res_d, bit_q, bit_d, sum;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sum    = res_q + bit_q;
    if (start_i) begin
      rem_d  = radicand_i;
      res_d  = '0;
      bit_d  = 64'd1 << 62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= sum) begin
        rem_d = rem_q - sum;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      res_q  <= res_d;
      bit_q  <= bit_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

FILE: rtl/mel_div.sv
`timescale 1ns / 1ps
// Restoring divider: (diff << LOG_FRAC_BITS) / den, one bit per cycle,
// saturated to 32 bits. Depends on mel_pkg.
module mel_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mel_pkg::word_t  diff_i,
  input  mel_pkg::dword_t den_i,
  output logic            done_o,
  output mel_pkg::word_t  quot_o
);

  logic [mel_pkg::DIV_BITS-1:0]  num_q, num_d;
  logic [mel_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  mel_pkg::dword_t rem_q, rem_d, den_q, den_d;
  mel_pkg::word_t  q_q, q_d;
  logic [64:0] r65, diff65;
  logic ge, over_q, over_d, busy_q, busy_d, done_q, done_d;

  always_comb begin
    num_d  = num_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    q_d    = q_q;
    over_d = over_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r65    = {rem_q, num_q[mel_pkg::DIV_BITS-1]};
    diff65 = r65 - {1'b0, den_q};
    ge     = (r65 >= {1'b0, den_q});
    if (start_i) begin
      num_d  = {diff_i, {mel_pkg::LOG_FRAC_BITS{1'b0}}};
      cnt_d  = mel_pkg::DIV_CNT_W'(mel_pkg::DIV_BITS - 1);
      rem_d  = '0;
      den_d  = den_i;
      q_d    = '0;
      over_d = 1'b0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = ge ? diff65[63:0] : r65[63:0];
      q_d   = {q_q[30:0], ge};
      if (ge && cnt_q >= mel_pkg::DIV_CNT_W'(32)) begin
        over_d = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      q_q    <= '0;
      over_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      num_q  <= num_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      q_q    <= q_d;
      over_q <= over_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = over_q ? 32'hFFFF_FFFF : q_q;

endmodule

FILE: rtl/metric_edge_length_geometric_core.sv
`timescale 1ns / 1ps
// Metric edge length core: geometric size interpolation along a straight edge.
// Depends on mel_pkg, mel_mul, mel_sqrt and mel_div.
//
// Usage: each edge arrives as two items on the s_axis channel. Both carry the
// edge vector, each the metric tensor of one endpoint; s_axis_tuser is 0 for
// the first endpoint and 1 for the second. A first item only updates the
// stored start size. A second item yields one item on m_axis holding the
// edge length, both endpoint sizes and the degenerate flag.
// Configuration (dimension mode, size threshold) is written on the cfg port,
// which is always ready; write it only while the core is idle.
// Sequence: every product goes through one registered 32x32 multiplier, four
// partial products per wide multiply. Each term of the quadratic form takes
// two wide multiplies (three terms in 2D, six in 3D) and the square root
// follows the last term. A second item adds two log2 evaluations (normalize,
// then 58 squarings), one wide multiply by ln 2 and a division.
// s_axis_tready is high only while the core is idle. A result waits in the
// output register while m_axis_tready is low; the next item is accepted
// meanwhile, and its result waits until the previous one is taken.
// Reset clears the stored start size to 0, mode to 3D and threshold to 1.
module metric_edge_length_geometric_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // cfg write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // delta_x, delta_y, delta_z, metric_xx, metric_xy, metric_yy, metric_xz,
  // metric_yz, metric_zz (32 bits each, from bit 0 up)
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // is_end_point
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // edge_length, size_start, size_end (32 bits each, from bit 0 up)
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tuser    // degenerate
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TERM  = 4'd1;
  localparam logic [3:0] S_TERM2 = 4'd2;
  localparam logic [3:0] S_TERM3 = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SQRT0 = 4'd5;
  localparam logic [3:0] S_SQRTW = 4'd6;
  localparam logic [3:0] S_LNORM = 4'd7;
  localparam logic [3:0] S_LSQ   = 4'd8;
  localparam logic [3:0] S_LUPD  = 4'd9;
  localparam logic [3:0] S_DIFF  = 4'd10;
  localparam logic [3:0] S_DEN   = 4'd11;
  localparam logic [3:0] S_DIVW  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam int FB = mel_pkg::LOG_FRAC_BITS;

  // control
  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [2:0] ph_q, ph_d, term_q, term_d;
  // wide multiply operands and product
  mel_pkg::dword_t opa_q, opa_d, opb_q, opb_d;
  logic [127:0] prod_q, prod_d;
  // latched item
  mel_pkg::word_t dxm_q, dxm_d, dym_q, dym_d, dzm_q, dzm_d;
  logic [2:0] ds_q, ds_d;
  mel_pkg::word_t mm_q [6];
  mel_pkg::word_t mm_d [6];
  logic [5:0] ms_q, ms_d;
  logic end_q, end_d;
  logic [99:0] acc_q, acc_d;
  // sizes and log state
  mel_pkg::word_t s1_q, s1_d, stored_q, stored_d, len_q, len_d;
  logic deg_q, deg_d;
  mel_pkg::dword_t y_q, y_d;
  logic [4:0] n_q, n_d;
  logic [FB-1:0] rb_q, rb_d;
  logic [5:0] b_q, b_d;
  logic lsel_q, lsel_d;
  logic [FB+4:0] l0_q, l0_d, l1_q, l1_d, dl;
  // config and output
  logic [1:0] dim_q, dim_d;
  logic [15:0] thr_q, thr_d;
  mel_pkg::word_t out_len_q, out_len_d, out_s0_q, out_s0_d, out_s1_q, out_s1_d;
  logic out_deg_q, out_deg_d, out_valid_q, out_valid_d;

  // shared-unit hookups
  mel_pkg::word_t mul_a, mul_b, di, dj, root, quot, diff;
  mel_pkg::dword_t mul_p, radicand;
  logic si, sj, neg, twice, sqrt_start, sqrt_done, div_start, div_done;
  logic [96:0] mag97;
  logic [99:0] addend;
  logic [2:0] last_term;
  logic sq_bit;
  logic [FB-1:0] rb_next;

  logic s_accept, cfg_accept;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_accept    = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Feed the multiplier one partial product per phase: a0b0, a0b1, a1b0, a1b1
  always_comb begin
    case (ph_q)
      3'd0:    begin mul_a = opa_q[31:0];  mul_b = opb_q[31:0];  end
      3'd1:    begin mul_a = opa_q[31:0];  mul_b = opb_q[63:32]; end
      3'd2:    begin mul_a = opa_q[63:32]; mul_b = opb_q[31:0];  end
      default: begin mul_a = opa_q[63:32]; mul_b = opb_q[63:32]; end
    endcase
  end

  // Pick the vector components, their signs and doubling for the term
  always_comb begin
    case (term_q)
      3'd0:    begin di = dxm_q; dj = dxm_q; si = ds_q[0]; sj = ds_q[0]; twice = 1'b0; end
      3'd1:    begin di = dxm_q; dj = dym_q; si = ds_q[0]; sj = ds_q[1]; twice = 1'b1; end
      3'd2:    begin di = dym_q; dj = dym_q; si = ds_q[1]; sj = ds_q[1]; twice = 1'b0; end
      3'd3:    begin di = dxm_q; dj = dzm_q; si = ds_q[0]; sj = ds_q[2]; twice = 1'b1; end
      3'd4:    begin di = dym_q; dj = dzm_q; si = ds_q[1]; sj = ds_q[2]; twice = 1'b1; end
      default: begin di = dzm_q; dj = dzm_q; si = ds_q[2]; sj = ds_q[2]; twice = 1'b0; end
    endcase
  end

  assign last_term = (dim_q == mel_pkg::DIM_2D) ? 3'd2 : 3'd5;
  assign neg       = si ^ sj ^ ms_q[term_q];
  assign mag97     = twice ? {prod_q[95:0], 1'b0} : {1'b0, prod_q[95:0]};
  assign addend    = neg ? (~{3'd0, mag97} + 100'd1) : {3'd0, mag97};

  // Floor the form to Q32.32; negative gives 0, overflow saturates
  assign radicand = acc_q[99] ? '0 :
                    (|acc_q[98:80]) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_q[79:16];

  assign sq_bit  = prod_q[127];
  assign rb_next = {rb_q[FB-2:0], sq_bit};
  assign dl      = (l0_q > l1_q) ? (l0_q - l1_q) : (l1_q - l0_q);
  assign diff    = (stored_q > s1_q) ? (stored_q - s1_q) : (s1_q - stored_q);

  assign sqrt_start = (state_q == S_SQRT0);
  assign div_start  = (state_q == S_DEN) && (prod_q[127:64] != '0);

  mel_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mel_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  mel_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff),
    .den_i   (prod_q[127:64]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;  ret_d = ret_q;  ph_d = ph_q;  term_d = term_q;
    opa_d = opa_q;  opb_d = opb_q;  prod_d = prod_q;
    dxm_d = dxm_q;  dym_d = dym_q;  dzm_d = dzm_q;  ds_d = ds_q;
    mm_d = mm_q;  ms_d = ms_q;  end_d = end_q;  acc_d = acc_q;
    s1_d = s1_q;  stored_d = stored_q;  len_d = len_q;  deg_d = deg_q;
    y_d = y_q;  n_d = n_q;  rb_d = rb_q;  b_d = b_q;  lsel_d = lsel_q;
    l0_d = l0_q;  l1_d = l1_q;
    dim_d = dim_q;  thr_d = thr_q;
    out_len_d = out_len_q;  out_s0_d = out_s0_q;  out_s1_d = out_s1_q;
    out_deg_d = out_deg_q;  out_valid_d = out_valid_q;

    if (cfg_accept) begin
      case (cfg_index_i)
        mel_pkg::CFG_DIM: dim_d = cfg_data_i[1:0];
        mel_pkg::CFG_THR: thr_d = cfg_data_i;
        default: ;
      endcase
    end

    // drop the result once taken
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          dxm_d = mel_pkg::mag32(s_axis_tdata[31:0]);
          dym_d = mel_pkg::mag32(s_axis_tdata[63:32]);
          dzm_d = mel_pkg::mag32(s_axis_tdata[95:64]);
          ds_d  = {s_axis_tdata[95], s_axis_tdata[63], s_axis_tdata[31]};
          for (int k = 0; k < 6; k++) begin
            mm_d[k] = mel_pkg::mag32(s_axis_tdata[96+32*k +: 32]);
            ms_d[k] = s_axis_tdata[127+32*k];
          end
          end_d   = s_axis_tuser;
          acc_d   = '0;
          term_d  = '0;
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        if (term_q > last_term) begin
          state_d = S_SQRT0;
        end else begin
          opa_d   = {32'd0, di};
          opb_d   = {32'd0, dj};
          ret_d   = S_TERM2;
          state_d = S_MUL;
        end
      end
      S_TERM2: begin
        opa_d   = prod_q[63:0];
        opb_d   = {32'd0, mm_q[term_q]};
        ret_d   = S_TERM3;
        state_d = S_MUL;
      end
      S_TERM3: begin
        acc_d   = acc_q + addend;
        term_d  = term_q + 3'd1;
        state_d = S_TERM;
      end
      S_MUL: begin
        // accumulate the partial issued in the previous cycle
        case (ph_q)
          3'd0:    prod_d = prod_q;
          3'd1:    prod_d = {64'd0, mul_p};
          3'd2:    prod_d = prod_q + {32'd0, mul_p, 32'd0};
          3'd3:    prod_d = prod_q + {32'd0, mul_p, 32'd0};
          default: prod_d = prod_q + {mul_p, 64'd0};
        endcase
        if (ph_q == 3'd4) begin
          ph_d    = '0;
          state_d = ret_q;
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end
      S_SQRT0: state_d = S_SQRTW;
      S_SQRTW: begin
        if (sqrt_done) begin
          if (!end_q) begin
            stored_d = root;
            state_d  = S_IDLE;
          end else begin
            s1_d  = root;
            deg_d = 1'b0;
            len_d = '0;
            if (root < {16'd0, thr_q} || root == '0) begin
              deg_d   = 1'b1;
              state_d = S_OUT;
            end else if (stored_q == root) begin
              len_d   = root;
              state_d = S_OUT;
            end else if (stored_q == '0) begin
              state_d = S_OUT;
            end else begin
              lsel_d  = 1'b0;
              y_d     = {stored_q, 32'd0};
              n_d     = 5'd31;
              state_d = S_LNORM;
            end
          end
        end
      end
      S_LNORM: begin
        // normalize the mantissa one bit a cycle
        if (y_q[63]) begin
          b_d     = 6'(FB - 1);
          rb_d    = '0;
          state_d = S_LSQ;
        end else begin
          y_d = y_q << 1;
          n_d = n_q - 5'd1;
        end
      end
      S_LSQ: begin
        opa_d   = y_q;
        opb_d   = y_q;
        ret_d   = S_LUPD;
        state_d = S_MUL;
      end
      S_LUPD: begin
        y_d  = sq_bit ? prod_q[127:64] : prod_q[126:63];
        rb_d = rb_next;
        if (b_q == '0) begin
          if (!lsel_q) begin
            l0_d    = {n_q, rb_next};
            lsel_d  = 1'b1;
            y_d     = {s1_q, 32'd0};
            n_d     = 5'd31;
            state_d = S_LNORM;
          end else begin
            l1_d    = {n_q, rb_next};
            state_d = S_DIFF;
          end
        end else begin
          b_d     = b_q - 6'd1;
          state_d = S_LSQ;
        end
      end
      S_DIFF: begin
        if (dl == '0) begin
          len_d   = s1_q;
          state_d = S_OUT;
        end else begin
          opa_d   = {1'b0, dl};
          opb_d   = mel_pkg::LN2_Q64;
          ret_d   = S_DEN;
          state_d = S_MUL;
        end
      end
      S_DEN: begin
        if (prod_q[127:64] == '0) begin
          len_d   = s1_q;
          state_d = S_OUT;
        end else begin
          state_d = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          len_d   = quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_len_d   = len_q;
          out_s0_d    = stored_q;
          out_s1_d    = s1_q;
          out_deg_d   = deg_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  ret_q <= S_IDLE;  ph_q <= '0;  term_q <= '0;
      opa_q <= '0;  opb_q <= '0;  prod_q <= '0;
      dxm_q <= '0;  dym_q <= '0;  dzm_q <= '0;  ds_q <= '0;
      for (int k = 0; k < 6; k++) mm_q[k] <= '0;
      ms_q <= '0;  end_q <= 1'b0;  acc_q <= '0;
      s1_q <= '0;  stored_q <= '0;  len_q <= '0;  deg_q <= 1'b0;
      y_q <= '0;  n_q <= '0;  rb_q <= '0;  b_q <= '0;  lsel_q <= 1'b0;
      l0_q <= '0;  l1_q <= '0;
      dim_q <= 2'd3;  thr_q <= 16'd1;
      out_len_q <= '0;  out_s0_q <= '0;  out_s1_q <= '0;
      out_deg_q <= 1'b0;  out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  ret_q <= ret_d;  ph_q <= ph_d;  term_q <= term_d;
      opa_q <= opa_d;  opb_q <= opb_d;  prod_q <= prod_d;
      dxm_q <= dxm_d;  dym_q <= dym_d;  dzm_q <= dzm_d;  ds_q <= ds_d;
      mm_q <= mm_d;  ms_q <= ms_d;  end_q <= end_d;  acc_q <= acc_d;
      s1_q <= s1_d;  stored_q <= stored_d;  len_q <= len_d;  deg_q <= deg_d;
      y_q <= y_d;  n_q <= n_d;  rb_q <= rb_d;  b_q <= b_d;  lsel_q <= lsel_d;
      l0_q <= l0_d;  l1_q <= l1_d;
      dim_q <= dim_d;  thr_q <= thr_d;
      out_len_q <= out_len_d;  out_s0_q <= out_s0_d;  out_s1_q <= out_s1_d;
      out_deg_q <= out_deg_d;  out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_s1_q, out_s0_q, out_len_q};
  assign m_axis_tuser  = out_deg_q;

  // A degenerate edge always reports zero length
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == '0)
    else $error("degenerate edge with nonzero length");

  // An accepted item keeps the core busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("core ready right after accepting an item");

  // The square root only finishes while the sequencer waits for it
  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRTW)
    else $error("square root finished outside its wait state");

  // The divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVW)
    else $error("division finished outside its wait state");

endmodule
